// ----- design/drp_pkg.sv -----
// ----------------------------------------------------------------------------
// drp_pkg: shared types and codes for the DMA ring read-pointer manager
// Command modes, configuration register indexes and the controller command
// bundle that drives the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package drp_pkg;

  // command modes
  localparam logic [2:0] MODE_SET_WR = 3'd0;
  localparam logic [2:0] MODE_PEEK   = 3'd1;
  localparam logic [2:0] MODE_SKIP   = 3'd2;
  localparam logic [2:0] MODE_READ   = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOAD  = 4'd1;

  // controller to datapath step strobes
  typedef struct packed {
    logic cap;     // latch item, form raw differences
    logic wrap;    // fold differences back into the ring
    logic commit;  // decide, update pointers, build segments
    logic free;    // compute free space
  } drp_cmd_t;

endpackage

`default_nettype wire

// ----- design/drp_if.sv -----
// ----------------------------------------------------------------------------
// drp_if: valid/ready channels of the ring read-pointer manager
// Command channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface drp_cmd_if #(parameter int unsigned OFFSET_BITS = 24);
  logic                   valid;
  logic                   ready;
  logic [2:0]             mode;
  logic [OFFSET_BITS-1:0] new_write_offset;
  logic [OFFSET_BITS-1:0] byte_count;

  modport source (output valid, mode, new_write_offset, byte_count, input ready);
  modport sink   (input valid, mode, new_write_offset, byte_count, output ready);
endinterface

interface drp_res_if #(parameter int unsigned OFFSET_BITS = 24);
  logic                   valid;
  logic                   ready;
  logic                   status;
  logic [OFFSET_BITS-1:0] first_segment_offset;
  logic [OFFSET_BITS-1:0] first_segment_length;
  logic [OFFSET_BITS-1:0] second_segment_length;
  logic [OFFSET_BITS-1:0] current_read_offset;
  logic [OFFSET_BITS-1:0] current_load;
  logic [OFFSET_BITS-1:0] current_free;

  modport source (output valid, status, first_segment_offset, first_segment_length,
                  second_segment_length, current_read_offset, current_load,
                  current_free, input ready);
  modport sink   (input valid, status, first_segment_offset, first_segment_length,
                  second_segment_length, current_read_offset, current_load,
                  current_free, output ready);
endinterface

interface drp_cfg_if #(parameter int unsigned OFFSET_BITS = 24);
  import drp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [OFFSET_BITS:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/drp_ctrl.sv -----
// ----------------------------------------------------------------------------
// drp_ctrl: command sequencer
// Takes one item, steps the datapath through its phases and holds the
// result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module drp_ctrl
  import drp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output drp_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WRAP   = 3'd1;
  localparam logic [2:0] ST_COMMIT = 3'd2;
  localparam logic [2:0] ST_FREE   = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  logic [2:0] state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_WRAP;
      ST_WRAP:   state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = ST_FREE;
      ST_FREE:   state_nxt = ST_OUT;
      ST_OUT:    if (out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // handshake and step strobes
  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = (state_r == ST_OUT);
  assign cmd.cap    = in_ready && in_valid;
  assign cmd.wrap   = (state_r == ST_WRAP);
  assign cmd.commit = (state_r == ST_COMMIT);
  assign cmd.free   = (state_r == ST_FREE);

endmodule

`default_nettype wire

// ----- design/drp_dp.sv -----
// ----------------------------------------------------------------------------
// drp_dp: ring pointer datapath
// Holds ring size, max load and the two offsets; computes load, copy
// segments and free space one phase per controller strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module drp_dp
  import drp_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire drp_cmd_t               cmd,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [OFFSET_BITS:0]   cfg_data,
  input  wire logic [2:0]             mode,
  input  wire logic [OFFSET_BITS-1:0] new_write_offset,
  input  wire logic [OFFSET_BITS-1:0] byte_count,
  output logic                        status,
  output logic [OFFSET_BITS-1:0]      first_segment_offset,
  output logic [OFFSET_BITS-1:0]      first_segment_length,
  output logic [OFFSET_BITS-1:0]      second_segment_length,
  output logic [OFFSET_BITS-1:0]      current_read_offset,
  output logic [OFFSET_BITS-1:0]      current_load,
  output logic [OFFSET_BITS-1:0]      current_free
);

  localparam int unsigned OB = OFFSET_BITS;
  localparam int unsigned SW = OFFSET_BITS + 1;

  // configuration and pointers
  logic [SW-1:0] ring_size_r;
  logic [OB-1:0] max_load_r;
  logic [OB-1:0] rp_r, rp_nxt;
  logic [OB-1:0] wp_r, wp_nxt;

  // captured item
  logic [2:0]    mode_r;
  logic [OB-1:0] wofs_r;
  logic [OB-1:0] len_r;
  logic          cfg_ok_r;
  logic          wofs_lt_r;

  // intermediate results
  logic [SW-1:0] dcur_r;     // wp - rp, unfolded
  logic [SW-1:0] dnew_r;     // new wp - rp, unfolded
  logic [SW-1:0] to_end_r;   // ring_size - rp
  logic [SW-1:0] np_r;       // rp + len, unfolded
  logic [OB-1:0] load_r;
  logic [OB-1:0] dist_new_r;
  logic [OB-1:0] np_w_r;

  // result registers
  logic          status_r, status_nxt;
  logic [OB-1:0] seg_ofs_r, seg_ofs_nxt;
  logic [OB-1:0] seg1_r, seg1_nxt;
  logic [OB-1:0] seg2_r, seg2_nxt;
  logic [OB-1:0] load_fin_r, load_fin_nxt;
  logic [OB-1:0] free_r;

  logic          cfg_hit;
  logic [SW-1:0] dcur_fold, dnew_fold;

  assign cfg_hit = cfg_we && ((cfg_index == CFG_RING_SIZE) || (cfg_index == CFG_MAX_LOAD));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_size_r <= '0;
      max_load_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_RING_SIZE) ring_size_r <= cfg_data;
      if (cfg_index == CFG_MAX_LOAD)  max_load_r  <= cfg_data[OB-1:0];
    end
  end

  // capture: latch item and form raw differences
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      mode_r    <= mode;
      wofs_r    <= new_write_offset;
      len_r     <= byte_count;
      cfg_ok_r  <= (ring_size_r != '0) && (max_load_r != '0) &&
                   ({1'b0, max_load_r} < ring_size_r);
      wofs_lt_r <= ({1'b0, new_write_offset} < ring_size_r);
      dcur_r    <= {1'b0, wp_r} - {1'b0, rp_r};
      dnew_r    <= {1'b0, new_write_offset} - {1'b0, rp_r};
      to_end_r  <= ring_size_r - {1'b0, rp_r};
      np_r      <= {1'b0, rp_r} + {1'b0, byte_count};
    end
  end

  // wrap: a borrow means the span crosses the ring end
  assign dcur_fold = dcur_r[SW-1] ? (dcur_r + ring_size_r) : dcur_r;
  assign dnew_fold = dnew_r[SW-1] ? (dnew_r + ring_size_r) : dnew_r;

  always_ff @(posedge clk) begin
    if (cmd.wrap) begin
      load_r     <= dcur_fold[OB-1:0];
      dist_new_r <= dnew_fold[OB-1:0];
      np_w_r     <= (np_r >= ring_size_r) ? OB'(np_r - ring_size_r) : np_r[OB-1:0];
    end
  end

  // commit: accept or refuse, move pointers, split the copy at the wrap
  always_comb begin
    rp_nxt       = rp_r;
    wp_nxt       = wp_r;
    status_nxt   = 1'b1;
    seg_ofs_nxt  = '0;
    seg1_nxt     = '0;
    seg2_nxt     = '0;
    load_fin_nxt = cfg_ok_r ? load_r : '0;
    if (mode_r == MODE_CLEAR) begin
      rp_nxt       = wp_r;
      status_nxt   = 1'b0;
      load_fin_nxt = '0;
    end else if (cfg_ok_r && (mode_r == MODE_SET_WR)) begin
      if (wofs_lt_r && (dist_new_r <= max_load_r)) begin
        wp_nxt       = wofs_r;
        status_nxt   = 1'b0;
        load_fin_nxt = dist_new_r;
      end
    end else if (cfg_ok_r && (mode_r inside {MODE_PEEK, MODE_SKIP, MODE_READ})) begin
      if (len_r <= load_r) begin
        status_nxt = 1'b0;
        if (mode_r != MODE_SKIP) begin
          seg_ofs_nxt = rp_r;
          if ({1'b0, len_r} <= to_end_r) begin
            seg1_nxt = len_r;
          end else begin
            seg1_nxt = to_end_r[OB-1:0];
            seg2_nxt = len_r - to_end_r[OB-1:0];
          end
        end
        if (mode_r != MODE_PEEK) begin
          rp_nxt       = np_w_r;
          load_fin_nxt = load_r - len_r;
        end
      end
    end
  end

  // pointers: cleared by reset and by any write to ring size or max load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r <= '0;
      wp_r <= '0;
    end else if (cfg_hit) begin
      rp_r <= '0;
      wp_r <= '0;
    end else if (cmd.commit) begin
      rp_r <= rp_nxt;
      wp_r <= wp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r   <= status_nxt;
      seg_ofs_r  <= seg_ofs_nxt;
      seg1_r     <= seg1_nxt;
      seg2_r     <= seg2_nxt;
      load_fin_r <= load_fin_nxt;
    end
  end

  // free space
  always_ff @(posedge clk) begin
    if (cmd.free) begin
      free_r <= (cfg_ok_r && (load_fin_r < max_load_r)) ? (max_load_r - load_fin_r) : '0;
    end
  end

  assign status                = status_r;
  assign first_segment_offset  = seg_ofs_r;
  assign first_segment_length  = seg1_r;
  assign second_segment_length = seg2_r;
  assign current_read_offset   = rp_r;
  assign current_load          = load_fin_r;
  assign current_free          = free_r;

endmodule

`default_nettype wire

// ----- design/dma_ring_read_pointer_manager_core.sv -----
// ----------------------------------------------------------------------------
// dma_ring_read_pointer_manager_core: DMA ring read-pointer manager
// Keeps read and write offsets of a ring with a reserve and reports the copy
// segments, load and free space for every command.
// ----------------------------------------------------------------------------
// One command at a time: the item is taken in the cycle it is offered while
// idle, and the controller steps the datapath through capture, wrap fold,
// commit and free-space phases before presenting the result. A new command
// is accepted only after the result has been taken.
// Each command returns exactly one result; status 1 means refused with the
// pointers unchanged. Configuration writes are always ready and take effect in
// the next cycle; those to ring_size or max_load return both offsets to zero;
// they belong between commands. Until ring_size is nonzero and max_load lies
// in 1..ring_size-1, every command but clear is refused and load and free read zero.
`default_nettype none

module dma_ring_read_pointer_manager_core
  import drp_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 24
) (
  input wire logic clk,
  input wire logic rst_n,
  drp_cmd_if.sink  in_ch,
  drp_res_if.source out_ch,
  drp_cfg_if.sink  cfg_ch
);

  drp_cmd_t cmd;

  assign cfg_ch.ready = 1'b1;

  drp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  drp_dp #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .cfg_we                (cfg_ch.valid && cfg_ch.ready),
    .cfg_index             (cfg_ch.index),
    .cfg_data              (cfg_ch.data),
    .mode                  (in_ch.mode),
    .new_write_offset      (in_ch.new_write_offset),
    .byte_count            (in_ch.byte_count),
    .status                (out_ch.status),
    .first_segment_offset  (out_ch.first_segment_offset),
    .first_segment_length  (out_ch.first_segment_length),
    .second_segment_length (out_ch.second_segment_length),
    .current_read_offset   (out_ch.current_read_offset),
    .current_load          (out_ch.current_load),
    .current_free          (out_ch.current_free)
  );

  // only one item in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("item accepted while another is in flight");

  a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input ready while a result is pending");

  a_idle_after_delivery: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready) |=> (in_ch.ready && !out_ch.valid))
    else $error("controller not idle after result taken");

  // a refused command carries no copy
  a_refused_no_copy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status) |->
      ((out_ch.first_segment_offset == '0) && (out_ch.first_segment_length == '0) &&
       (out_ch.second_segment_length == '0)))
    else $error("refused command reports a copy segment");

endmodule

`default_nettype wire
